// ===== hw/rtl/smd_pkg.sv =====
// shared types, constants and helpers for the spring-damper point mass block
package smd_pkg;

    localparam int AXES   = 3;
    localparam int AXIS_W = 2;
    localparam int CFG_IDX_W = 2;

    // reciprocal of a 0.001 kg point mass, 1000 in q16.16
    localparam logic [31:0] INV_MASS_RESET = 32'd65536000;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } smd_opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STIFFNESS    = 2'd0,
        REG_DAMPING      = 2'd1,
        REG_INVERSE_MASS = 2'd2
    } smd_reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SPRING_MUL,
        ST_SPRING_ACC,
        ST_DAMP_MUL,
        ST_DAMP_ACC,
        ST_ACCEL_MUL,
        ST_ACCEL_ACC,
        ST_DV_MUL,
        ST_DV_ACC,
        ST_DP_MUL,
        ST_DP_ACC,
        ST_OUT
    } smd_state_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] proxy_x;
        logic signed [31:0] proxy_y;
        logic signed [31:0] proxy_z;
        logic [31:0]        delta_t;
    } smd_in_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } smd_out_t;

    // control word for one pass through the shared multiplier
    typedef struct packed {
        logic issue;
        logic flip;
        logic sh32;
    } smd_op_t;

    function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == SAT_MIN) begin
            r = SAT_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/smd_mul_unit.sv =====
// shared multiply, shift, saturate and accumulate unit
module smd_mul_unit (
    input  logic               aclk,
    input  smd_pkg::smd_op_t   op,
    input  logic [31:0]        opnd_a,
    input  logic signed [32:0] opnd_x,
    input  logic signed [31:0] addend,
    output logic signed [31:0] result
);
    import smd_pkg::*;

    logic [64:0]        prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic               sh32_reg;
    logic signed [31:0] addend_reg;

    logic        x_neg;
    logic [32:0] x_inv;
    logic [48:0] shifted;
    logic [31:0] lim, mag;
    logic signed [33:0] add_ext, mag_ext, sum;

    // |x| * a as a * ~x + a for negative x
    always_comb begin
        x_neg     = opnd_x[32];
        x_inv     = x_neg ? ~opnd_x : opnd_x;
        prod_next = 65'(opnd_a) * 65'(x_inv) + (x_neg ? 65'(opnd_a) : 65'd0);
        neg_next  = x_neg ^ op.flip;
    end

    always_ff @(posedge aclk) begin
        if (op.issue) begin
            prod_reg   <= prod_next;
            neg_reg    <= neg_next;
            sh32_reg   <= op.sh32;
            addend_reg <= addend;
        end
    end

    // truncate toward zero, clamp magnitude, apply sign with the add
    always_comb begin
        shifted = sh32_reg ? {16'd0, prod_reg[64:32]} : prod_reg[64:16];
        lim     = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
        mag     = (shifted > {17'd0, lim}) ? lim : shifted[31:0];
        add_ext = 34'(addend_reg);
        mag_ext = $signed({2'b00, mag});
        sum     = neg_reg ? add_ext - mag_ext : add_ext + mag_ext;
        if (sum > 34'(SAT_MAX)) begin
            result = SAT_MAX;
        end else if (sum < 34'(SAT_MIN)) begin
            result = SAT_MIN;
        end else begin
            result = sum[31:0];
        end
    end

endmodule

// ===== hw/rtl/spring_damper_point_mass_step_top.sv =====
// top level of the three-axis spring-damper point mass step
// A start item (opcode 0) places the virtual mass at the device position and clears its
// velocity in the cycle it is accepted; it gives no result. A tick item (opcode 1) runs
// the spring-damper force, the explicit Euler velocity step and then the position step
// for x, y and z in turn, state and forces in signed q16.16 and the time step in unsigned
// q0.32, with truncation toward zero and 32-bit saturation, and returns one item holding
// the negated force. Every product goes through one shared 32x33 multiplier with a
// registered product, so each axis runs the position difference and then a multiply and
// an accumulate state per product (spring, damper, acceleration, velocity step, position
// step). After the last axis the output state loads the output register, holding while
// the previous result still waits on m_ready, then returns to idle and raises s_ready. A
// finished result sits in its own output register, so the next item is accepted while it
// waits. Configuration registers (stiffness, damping, inverse mass) are written through
// cfg_wr_en/cfg_index/cfg_wdata; writes to index 3 are dropped.
module spring_damper_point_mass_step_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  smd_pkg::smd_in_t                  s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output smd_pkg::smd_out_t                 m_item,
    input  logic                              cfg_wr_en,
    input  logic [smd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_wdata
);
    import smd_pkg::*;

    // sequencer
    smd_state_t state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;

    // configuration
    logic [31:0] stiffness_reg, damping_reg, inv_mass_reg;

    // mass state per axis
    logic signed [31:0] pos_reg [AXES];
    logic signed [31:0] pos_next [AXES];
    logic signed [31:0] vel_reg [AXES];
    logic signed [31:0] vel_next [AXES];

    // working registers of the current tick
    logic signed [31:0] proxy_reg [AXES];
    logic signed [31:0] proxy_next [AXES];
    logic signed [31:0] force_reg [AXES];
    logic signed [31:0] force_next [AXES];
    logic [31:0]        dt_reg, dt_next;
    logic signed [32:0] diff_reg, diff_next;
    logic signed [31:0] spring_reg, spring_next;
    logic signed [31:0] accel_reg, accel_next;

    // output register
    logic     out_valid_reg, out_valid_next;
    smd_out_t out_item_reg, out_item_next;

    // shared unit hookup
    smd_op_t            mul_op;
    logic [31:0]        mul_a;
    logic signed [32:0] mul_x;
    logic signed [31:0] mul_addend;
    logic signed [31:0] mul_result;

    logic in_accept;
    logic last_axis;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;
    assign last_axis = (axis_reg == AXIS_W'(AXES - 1));

    smd_mul_unit u_mul (
        .aclk   (aclk),
        .op     (mul_op),
        .opnd_a (mul_a),
        .opnd_x (mul_x),
        .addend (mul_addend),
        .result (mul_result)
    );

    // next state, operand selection and write-back
    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        dt_next        = dt_reg;
        diff_next      = diff_reg;
        spring_next    = spring_reg;
        accel_next     = accel_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !m_ready;
        for (int i = 0; i < AXES; i++) begin
            pos_next[i]   = pos_reg[i];
            vel_next[i]   = vel_reg[i];
            proxy_next[i] = proxy_reg[i];
            force_next[i] = force_reg[i];
        end

        mul_op     = '0;
        mul_a      = '0;
        mul_x      = '0;
        mul_addend = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_item.opcode == OP_START) begin
                        // start effect: mass jumps to the device, at rest
                        pos_next[0] = s_item.proxy_x;
                        pos_next[1] = s_item.proxy_y;
                        pos_next[2] = s_item.proxy_z;
                        for (int i = 0; i < AXES; i++) begin
                            vel_next[i] = '0;
                        end
                    end else begin
                        proxy_next[0] = s_item.proxy_x;
                        proxy_next[1] = s_item.proxy_y;
                        proxy_next[2] = s_item.proxy_z;
                        dt_next       = s_item.delta_t;
                        axis_next     = '0;
                        state_next    = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                // exact 33-bit spring stretch
                diff_next  = 33'(proxy_reg[axis_reg]) - 33'(pos_reg[axis_reg]);
                state_next = ST_SPRING_MUL;
            end
            ST_SPRING_MUL: begin
                mul_op.issue = 1'b1;
                mul_a        = stiffness_reg;
                mul_x        = diff_reg;
                state_next   = ST_SPRING_ACC;
            end
            ST_SPRING_ACC: begin
                spring_next = mul_result;
                state_next  = ST_DAMP_MUL;
            end
            ST_DAMP_MUL: begin
                // force = spring - c*v, damper term saturated first
                mul_op.issue = 1'b1;
                mul_op.flip  = 1'b1;
                mul_a        = damping_reg;
                mul_x        = 33'(vel_reg[axis_reg]);
                mul_addend   = spring_reg;
                state_next   = ST_DAMP_ACC;
            end
            ST_DAMP_ACC: begin
                force_next[axis_reg] = mul_result;
                state_next           = ST_ACCEL_MUL;
            end
            ST_ACCEL_MUL: begin
                mul_op.issue = 1'b1;
                mul_a        = inv_mass_reg;
                mul_x        = 33'(force_reg[axis_reg]);
                state_next   = ST_ACCEL_ACC;
            end
            ST_ACCEL_ACC: begin
                accel_next = mul_result;
                state_next = ST_DV_MUL;
            end
            ST_DV_MUL: begin
                // v += a*dt, the product never leaves 32 bits so one clamp is exact
                mul_op.issue = 1'b1;
                mul_op.sh32  = 1'b1;
                mul_a        = dt_reg;
                mul_x        = 33'(accel_reg);
                mul_addend   = vel_reg[axis_reg];
                state_next   = ST_DV_ACC;
            end
            ST_DV_ACC: begin
                vel_next[axis_reg] = mul_result;
                state_next         = ST_DP_MUL;
            end
            ST_DP_MUL: begin
                // m += v*dt with the new velocity
                mul_op.issue = 1'b1;
                mul_op.sh32  = 1'b1;
                mul_a        = dt_reg;
                mul_x        = 33'(vel_reg[axis_reg]);
                mul_addend   = pos_reg[axis_reg];
                state_next   = ST_DP_ACC;
            end
            ST_DP_ACC: begin
                pos_next[axis_reg] = mul_result;
                if (last_axis) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = ST_DIFF;
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_ready) begin
                    out_item_next.force_x = neg_sat32(force_reg[0]);
                    out_item_next.force_y = neg_sat32(force_reg[1]);
                    out_item_next.force_z = neg_sat32(force_reg[2]);
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and mass state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            stiffness_reg <= '0;
            damping_reg   <= '0;
            inv_mass_reg  <= INV_MASS_RESET;
            for (int i = 0; i < AXES; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < AXES; i++) begin
                pos_reg[i] <= pos_next[i];
                vel_reg[i] <= vel_next[i];
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STIFFNESS:    stiffness_reg <= cfg_wdata;
                    REG_DAMPING:      damping_reg   <= cfg_wdata;
                    REG_INVERSE_MASS: inv_mass_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // working payload, no reset needed
    always_ff @(posedge aclk) begin
        dt_reg       <= dt_next;
        diff_reg     <= diff_next;
        spring_reg   <= spring_next;
        accel_reg    <= accel_next;
        out_item_reg <= out_item_next;
        for (int i = 0; i < AXES; i++) begin
            proxy_reg[i] <= proxy_next[i];
            force_reg[i] <= force_next[i];
        end
    end

`ifndef SYNTHESIS
    // axis counter only ever walks x, y, z
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

    // a tick item starts the axis loop
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_item.opcode == OP_TICK) |=> (state_reg == ST_DIFF && axis_reg == '0))
        else $error("tick item did not start the axis loop");

    // a start item leaves the mass at rest
    a_start_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_item.opcode == OP_START) |=>
        (vel_reg[0] == '0 && vel_reg[1] == '0 && vel_reg[2] == '0))
        else $error("start item did not clear velocity");

    // a new result only appears out of the output state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output state");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(out_item_reg))
        else $error("pending result overwritten");
`endif

endmodule

// ===== bench/smd_force_checker.sv =====
// force predictor and result checker for the spring-damper point mass step
module smd_force_checker
    import smd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  smd_in_t              s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  smd_out_t             m_item,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    output int                   mismatches,
    output int                   pending_forces,
    output int                   forces_checked
);

    logic [31:0]        stiffness_q;
    logic [31:0]        damping_q;
    logic [31:0]        inv_mass_q;
    logic signed [31:0] mass_pos [AXES];
    logic signed [31:0] mass_vel [AXES];
    smd_out_t           force_queue [$];
    int                 n_bad = 0;
    int                 n_good = 0;

    assign mismatches     = n_bad;
    assign pending_forces = force_queue.size();
    assign forces_checked = n_good;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(SAT_MAX)) begin
            return SAT_MAX;
        end
        if (v < longint'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return v[31:0];
    endfunction

    // unsigned q16.16 gain times a signed value up to 33 bits, truncated toward zero
    function automatic longint scale_q16(input logic [31:0] gain, input longint b);
        longint unsigned g64;
        longint unsigned mag;
        longint unsigned r;
        g64 = gain;
        mag = (b < 0) ? -b : b;
        r = g64 * (mag >> 16) + ((g64 * (mag & 64'hffff)) >> 16);
        return (b < 0) ? -$signed(r) : $signed(r);
    endfunction

    // q0.32 time step times a signed q16.16 value, truncated toward zero
    function automatic longint step_q32(input logic [31:0] dt, input logic signed [31:0] b);
        longint unsigned d64;
        longint unsigned mag;
        longint unsigned r;
        d64 = dt;
        mag = (b < 0) ? -longint'(b) : longint'(b);
        r = (d64 * mag) >> 32;
        return (b < 0) ? -$signed(r) : $signed(r);
    endfunction

    task automatic advance_mass(input smd_in_t it);
        logic signed [31:0] proxy [AXES];
        logic signed [31:0] push_back [AXES];
        logic signed [31:0] spring, damper, pull, accel, dv, dp;
        smd_out_t           expected;
        proxy[0] = it.proxy_x;
        proxy[1] = it.proxy_y;
        proxy[2] = it.proxy_z;
        if (it.opcode == OP_START) begin
            for (int i = 0; i < AXES; i++) begin
                mass_pos[i] = proxy[i];
                mass_vel[i] = '0;
            end
            return;
        end
        for (int i = 0; i < AXES; i++) begin
            spring = clamp32(scale_q16(stiffness_q, longint'(proxy[i]) - longint'(mass_pos[i])));
            damper = clamp32(-scale_q16(damping_q, longint'(mass_vel[i])));
            pull   = clamp32(longint'(spring) + longint'(damper));
            accel  = clamp32(scale_q16(inv_mass_q, longint'(pull)));
            dv     = clamp32(step_q32(it.delta_t, accel));
            mass_vel[i] = clamp32(longint'(mass_vel[i]) + longint'(dv));
            dp     = clamp32(step_q32(it.delta_t, mass_vel[i]));
            mass_pos[i] = clamp32(longint'(mass_pos[i]) + longint'(dp));
            push_back[i] = clamp32(-longint'(pull));
        end
        expected.force_x = push_back[0];
        expected.force_y = push_back[1];
        expected.force_z = push_back[2];
        force_queue.push_back(expected);
    endtask

    always @(posedge aclk) begin
        smd_out_t want;
        if (!aresetn) begin
            stiffness_q = '0;
            damping_q   = '0;
            inv_mass_q  = INV_MASS_RESET;
            for (int i = 0; i < AXES; i++) begin
                mass_pos[i] = '0;
                mass_vel[i] = '0;
            end
            force_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STIFFNESS:    stiffness_q = cfg_wdata;
                    REG_DAMPING:      damping_q   = cfg_wdata;
                    REG_INVERSE_MASS: inv_mass_q  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (force_queue.size() == 0) begin
                    if (n_bad < 10) begin
                        $display("unexpected force item: x=%h y=%h z=%h",
                                 m_item.force_x, m_item.force_y, m_item.force_z);
                    end
                    n_bad++;
                end else begin
                    want = force_queue.pop_front();
                    if (want !== m_item) begin
                        if (n_bad < 10) begin
                            $display("force mismatch on item %0d: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                                     n_good + n_bad, want.force_x, want.force_y, want.force_z,
                                     m_item.force_x, m_item.force_y, m_item.force_z);
                        end
                        n_bad++;
                    end else begin
                        n_good++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_mass(s_item);
            end
        end
    end

endmodule

// ===== bench/spring_damper_point_mass_step_top_tb.sv =====
// stimulus and verdict for the spring-damper point mass step, checked by smd_force_checker
module spring_damper_point_mass_step_top_tb;
    import smd_pkg::*;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int RANDOM_PHASES = 6;
    // long enough to cover any tick work still in flight
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    // roughly one millisecond in q0.32 seconds
    localparam logic [31:0] DT_1MS = 32'd4294967;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    smd_in_t              s_item = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    smd_out_t             m_item;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;

    int mismatches;
    int pending_forces;
    int forces_checked;

    // idling odds in percent, changed per phase
    int send_idle = 0;
    int recv_idle = 0;
    // long receiver hold-off: bumped by the stimulus, followed by the receiver
    int hold_seq = 0;
    int hold_seen = 0;

    int n_items = 0;
    int n_starts = 0;
    int n_ticks = 0;
    int n_settings = 0;

    spring_damper_point_mass_step_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    smd_force_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .pending_forces (pending_forces),
        .forces_checked (forces_checked)
    );

    initial begin
        forever begin
            #1 aclk = ~aclk;
        end
    end

    // generous ceiling on the whole run
    initial begin
        #600000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random back-pressure, plus the occasional long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // position word: mostly near the origin, sometimes the rails or anything at all
    function automatic logic signed [31:0] pick_position();
        case ($urandom_range(9))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
        endcase
    endfunction

    // small drift of the device between two servo ticks, at most half a unit
    function automatic logic signed [31:0] nudge();
        return $signed($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_8000;
    endfunction

    // time step: a jittered servo period most of the time, with zero, full scale and noise
    function automatic logic [31:0] pick_step();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return DT_1MS + $urandom_range(0, 200000) - 100000;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_gains(input logic [31:0] k, input logic [31:0] c, input logic [31:0] inv_m);
        write_reg(REG_STIFFNESS, k);
        write_reg(REG_DAMPING, c);
        write_reg(REG_INVERSE_MASS, inv_m);
        n_settings++;
    endtask

    // stop offering, let every expected force come out, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_forces != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // offer one item and return at the edge where it is taken
    task automatic offer(input smd_opcode_t op, input logic signed [31:0] px,
                         input logic signed [31:0] py, input logic signed [31:0] pz,
                         input logic [31:0] dt);
        smd_in_t it;
        it.opcode  = op;
        it.proxy_x = px;
        it.proxy_y = py;
        it.proxy_z = pz;
        it.delta_t = dt;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        // inputs only move on rising edges, so the falling edge sees a settled ready
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        n_items++;
        if (op == OP_START) begin
            n_starts++;
        end else begin
            n_ticks++;
        end
    endtask

    // one effect: a start at some place, then the device wanders while the servo ticks
    task automatic run_track(input int ticks);
        logic signed [31:0] px, py, pz;
        px = pick_position();
        py = pick_position();
        pz = pick_position();
        offer(OP_START, px, py, pz, pick_step());
        repeat (ticks) begin
            px = px + nudge();
            py = py + nudge();
            pz = pz + nudge();
            offer(OP_TICK, px, py, pz, pick_step());
        end
    endtask

    initial begin
        int phase_end;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: unit spring, half damping, default mass
        load_gains(32'h0001_0000, 32'h0000_8000, INV_MASS_RESET);
        // index past the register list must be dropped
        write_reg(CFG_IDX_SPARE, 32'hffff_ffff);
        // tick before any start runs from the reset state
        offer(OP_TICK, 32'sh0001_8000, -32'sh0002_4000, 32'sh0000_c000, DT_1MS);
        // zero time step leaves the state alone but still gives a force
        offer(OP_TICK, 32'sh0001_8000, -32'sh0002_4000, 32'sh0000_c000, '0);
        offer(OP_START, SAT_MAX, SAT_MIN, '0, DT_1MS);
        offer(OP_TICK, SAT_MIN, SAT_MAX, 32'sh0000_0001, '1);
        offer(OP_TICK, SAT_MIN, SAT_MAX, 32'sh0000_0001, '0);
        offer(OP_START, '0, '0, '0, '0);
        settle();

        // every gain at full scale
        load_gains('1, '1, '1);
        // spring saturates at the negative rail, so the returned force must clamp high
        offer(OP_TICK, SAT_MIN, SAT_MIN, SAT_MIN, DT_1MS);
        offer(OP_TICK, SAT_MAX, SAT_MAX, SAT_MAX, '1);
        offer(OP_TICK, SAT_MAX, SAT_MIN, '0, '1);
        offer(OP_START, SAT_MIN, SAT_MAX, SAT_MIN, '1);
        offer(OP_TICK, SAT_MAX, SAT_MIN, SAT_MAX, '0);
        offer(OP_TICK, SAT_MAX, SAT_MIN, SAT_MAX, '1);
        settle();

        // every gain at zero
        load_gains('0, '0, '0);
        offer(OP_TICK, 32'sh0004_0000, -32'sh0004_0000, SAT_MAX, DT_1MS);
        offer(OP_START, 32'sh0000_0001, -32'sh0000_0001, '0, '0);
        offer(OP_TICK, SAT_MIN, SAT_MAX, 32'sh0000_0001, '1);
        settle();

        // stiff spring, light damper, small moves
        load_gains(32'h0010_0000, 32'h0000_2000, INV_MASS_RESET);
        offer(OP_START, '0, '0, '0, DT_1MS);
        offer(OP_TICK, 32'sh0000_1000, -32'sh0000_1000, 32'sh0000_0100, DT_1MS);
        offer(OP_TICK, 32'sh0000_2000, -32'sh0000_2000, 32'sh0000_0200, DT_1MS);
        offer(OP_TICK, 32'sh0000_3000, -32'sh0000_3000, 32'sh0000_0300, DT_1MS);
        settle();

        // random part: two gain settings under each idling pattern
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle <= 18;
                    recv_idle <= 63;
                end
                1: begin
                    send_idle <= 63;
                    recv_idle <= 18;
                end
                default: begin
                    send_idle <= 0;
                    recv_idle <= 0;
                end
            endcase
            case (phase)
                0:       load_gains(32'h0020_0000, 32'h0000_4000, INV_MASS_RESET);
                1:       load_gains($urandom, $urandom, $urandom);
                2:       load_gains(32'h0000_0100, 32'h0100_0000, 32'h0001_0000);
                3:       load_gains('1, '1, '1);
                4:       load_gains(32'h0004_0000, 32'h0000_1000, INV_MASS_RESET);
                default: load_gains($urandom, $urandom_range(0, 32'h0000_ffff), $urandom);
            endcase
            phase_end = n_items + RANDOM_ITEMS / RANDOM_PHASES;
            if (phase == 4) begin
                // receiver goes quiet for a long stretch while ticks keep coming,
                // so the output register fills and the input stalls
                hold_seq <= hold_seq + 1;
                run_track(24);
            end
            while (n_items < phase_end) begin
                if ($urandom_range(9) < 8) begin
                    run_track($urandom_range(4, 24));
                end else begin
                    // loose item with any opcode and any payload
                    offer(smd_opcode_t'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
                end
            end
            settle();
        end

        $display("ran %0d starts and %0d ticks under %0d gain settings, %0d forces checked",
                 n_starts, n_ticks, n_settings, forces_checked);
        if (mismatches == 0 && pending_forces == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
